### hdl/ring_neighbor_grant_arbiter_unit_macros.svh
// Assertion macros used by the arbiter control module.
`ifndef RING_NEIGHBOR_GRANT_ARBITER_UNIT_MACROS_SVH
`define RING_NEIGHBOR_GRANT_ARBITER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RNGA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RNGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rnga_pkg.sv
`timescale 1ns / 1ps
package rnga_pkg;

    localparam int FUNC_W         = 2;
    localparam int AGENT_W        = 3;
    localparam int RING_SIZE_W    = 4;
    localparam int WAIT_LIMIT_W   = 16;
    localparam int STAMP_W        = 32;
    localparam int PHASE_W        = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int MAX_AGENTS_DEF = 8;

    localparam logic [RING_SIZE_W-1:0]  RING_SIZE_RST  = 4'd8;
    localparam logic [WAIT_LIMIT_W-1:0] WAIT_LIMIT_RST = 16'd10;

    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REQ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REL  = 2'd2;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_GRANT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT = 2'd1;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [AGENT_W-1:0] agent;
    } t_in;

    typedef struct packed {
        logic [AGENT_W-1:0] granted_agent;
        logic               last;
    } t_out;

    typedef enum logic [2:0] {
        SEL_IN,
        SEL_A,
        SEL_L,
        SEL_R,
        SEL_LL,
        SEL_RR
    } t_sel;

    typedef struct packed {
        logic tick;
        logic load;
        logic clr_valid;
        logic rd_en;
        t_sel rd_sel;
        logic wr_en;
        t_sel wr_sel;
        logic wr_grant;
        logic wr_stamp_now;
        logic self_load;
        logic stop_load;
        logic stop_self_now;
        logic emit;
        t_sel emit_sel;
        logic emit_last;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic rd_idle;
        logic rd_wait;
        logic stop;
        logic stop_held;
    } t_sts;

endpackage

### hdl/rnga_ctrl.sv
`timescale 1ns / 1ps
`include "ring_neighbor_grant_arbiter_unit_macros.svh"
module rnga_ctrl
    import rnga_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [FUNC_W-1:0] i_func,
    input  t_sts              i_sts,
    output t_cmd              o_cmd,
    output logic              o_busy
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RQ_CHK,
        ST_RQ_RD_R,
        ST_RQ_FIN,
        ST_RL_RD_L,
        ST_RL_RD_LL,
        ST_RL_RD_R,
        ST_RL_RD_RR,
        ST_RL_FIN,
        ST_RL_OUT2
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_pass_l, n_pass_l;
    logic   r_tgt_wait, n_tgt_wait;
    logic   pass_l, pass_r;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        n_pass_l   = r_pass_l;
        n_tgt_wait = r_tgt_wait;
        pass_l     = r_tgt_wait && !i_sts.stop;
        pass_r     = r_tgt_wait && !i_sts.stop;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_func)
                        FUNC_TICK: begin
                            o_cmd.tick = 1'b1;
                        end
                        FUNC_REQ: begin
                            if (i_sts.in_range) begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_sel = SEL_IN;
                                o_cmd.load   = 1'b1;
                                n_state      = ST_RQ_CHK;
                            end
                        end
                        FUNC_REL: begin
                            if (i_sts.in_range) begin
                                o_cmd.clr_valid = 1'b1;
                                o_cmd.load      = 1'b1;
                                n_state         = ST_RL_RD_L;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RQ_CHK: begin
                if (i_sts.rd_idle) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = SEL_L;
                    n_state      = ST_RQ_RD_R;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_RQ_RD_R: begin
                o_cmd.rd_en         = 1'b1;
                o_cmd.rd_sel        = SEL_R;
                o_cmd.stop_self_now = 1'b1;
                o_cmd.stop_load     = 1'b1;
                n_state             = ST_RQ_FIN;
            end
            ST_RQ_FIN: begin
                o_cmd.stop_self_now = 1'b1;
                o_cmd.wr_en         = 1'b1;
                o_cmd.wr_sel        = SEL_A;
                o_cmd.wr_grant      = !i_sts.stop && !i_sts.stop_held;
                o_cmd.wr_stamp_now  = 1'b1;
                o_cmd.emit          = !i_sts.stop && !i_sts.stop_held;
                o_cmd.emit_sel      = SEL_A;
                o_cmd.emit_last     = 1'b1;
                n_state             = ST_IDLE;
            end
            ST_RL_RD_L: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = SEL_L;
                n_state      = ST_RL_RD_LL;
            end
            ST_RL_RD_LL: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sel    = SEL_LL;
                o_cmd.self_load = 1'b1;
                n_tgt_wait      = i_sts.rd_wait;
                n_state         = ST_RL_RD_R;
            end
            ST_RL_RD_R: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = SEL_R;
                o_cmd.wr_en    = pass_l;
                o_cmd.wr_sel   = SEL_L;
                o_cmd.wr_grant = 1'b1;
                n_pass_l       = pass_l;
                n_state        = ST_RL_RD_RR;
            end
            ST_RL_RD_RR: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sel    = SEL_RR;
                o_cmd.self_load = 1'b1;
                n_tgt_wait      = i_sts.rd_wait;
                n_state         = ST_RL_FIN;
            end
            ST_RL_FIN: begin
                o_cmd.wr_en    = pass_r;
                o_cmd.wr_sel   = SEL_R;
                o_cmd.wr_grant = 1'b1;
                if (r_pass_l) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = SEL_L;
                    o_cmd.emit_last = !pass_r;
                end else begin
                    o_cmd.emit      = pass_r;
                    o_cmd.emit_sel  = SEL_R;
                    o_cmd.emit_last = 1'b1;
                end
                n_state = (r_pass_l && pass_r) ? ST_RL_OUT2 : ST_IDLE;
            end
            ST_RL_OUT2: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_sel  = SEL_R;
                o_cmd.emit_last = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_busy = (n_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_busy     <= 1'b0;
            r_pass_l   <= 1'b0;
            r_tgt_wait <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_busy     <= n_busy;
            r_pass_l   <= n_pass_l;
            r_tgt_wait <= n_tgt_wait;
        end
    end

    assign o_busy = r_busy;

    `RNGA_ASSERT_NOW(a_out2_follows_fin, i_clk, i_rst_n, r_state == ST_RL_OUT2, $past(r_state) == ST_RL_FIN, "second grant beat without a preceding finish")
    `RNGA_ASSERT_NEXT(a_last_ends_item, i_clk, i_rst_n, o_cmd.emit && o_cmd.emit_last, r_state == ST_IDLE && !r_busy, "final beat did not end the item")
    `RNGA_ASSERT_NOW(a_no_rw_clash, i_clk, i_rst_n, o_cmd.wr_en && o_cmd.rd_en, o_cmd.rd_sel != o_cmd.wr_sel, "read and write hit the same table entry")
    `RNGA_ASSERT_NOW(a_left_first, i_clk, i_rst_n, r_state == ST_RL_FIN && r_pass_l, o_cmd.emit && o_cmd.emit_sel == SEL_L, "left grant not delivered first")

endmodule

### hdl/rnga_datapath.sv
`timescale 1ns / 1ps
module rnga_datapath
    import rnga_pkg::*;
#(
    parameter int MAX_AGENTS = MAX_AGENTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in                   i_in,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_res_valid,
    output t_out                  o_res
);

    localparam int AW = $clog2(MAX_AGENTS);
    localparam int NW = $clog2(MAX_AGENTS + 1);
    localparam int CW = (NW > RING_SIZE_W) ? NW : RING_SIZE_W;
    localparam int XW = (NW > AGENT_W) ? NW : AGENT_W;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    logic [RING_SIZE_W-1:0]  r_ring_size;
    logic [WAIT_LIMIT_W-1:0] r_wait_limit;
    logic [STAMP_W-1:0]      r_now;
    logic [AW-1:0]           r_a;
    t_entry                  r_mem [MAX_AGENTS];
    logic [MAX_AGENTS-1:0]   r_valid;
    t_entry                  r_rd_raw;
    logic                    r_rd_vld;
    logic [STAMP_W-1:0]      r_self_stamp;
    logic                    r_stop;
    logic                    r_res_valid;
    t_out                    r_res;

    logic [CW-1:0]      ring_ext;
    logic [CW-1:0]      ring_clamp;
    logic [NW-1:0]      ring_n;
    logic [AW-1:0]      last_idx;
    logic [AW-1:0]      in_idx;
    logic [AW-1:0]      a_l, a_r, a_ll, a_rr;
    logic [AW-1:0]      rd_addr, wr_addr, emit_addr;
    logic [PHASE_W-1:0] rd_phase;
    logic [STAMP_W-1:0] rd_stamp;
    logic [STAMP_W-1:0] self_stamp;
    logic [STAMP_W-1:0] waited;
    logic               older;
    logic               stop;
    t_entry             wr_entry;

    function automatic logic [AW-1:0] f_prev(input logic [AW-1:0] x, input logic [AW-1:0] top);
        return (x == '0) ? top : x - AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] x, input logic [AW-1:0] top);
        return (x == top) ? '0 : x + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_pick(
        input t_sel          s,
        input logic [AW-1:0] p_in,
        input logic [AW-1:0] p_a,
        input logic [AW-1:0] p_l,
        input logic [AW-1:0] p_r,
        input logic [AW-1:0] p_ll,
        input logic [AW-1:0] p_rr
    );
        unique case (s)
            SEL_IN:  f_pick = p_in;
            SEL_A:   f_pick = p_a;
            SEL_L:   f_pick = p_l;
            SEL_R:   f_pick = p_r;
            SEL_LL:  f_pick = p_ll;
            SEL_RR:  f_pick = p_rr;
            default: f_pick = p_a;
        endcase
    endfunction

    always_comb begin
        ring_ext = CW'(r_ring_size);
        if (ring_ext < CW'(3)) begin
            ring_clamp = CW'(3);
        end else if (ring_ext > CW'(MAX_AGENTS)) begin
            ring_clamp = CW'(MAX_AGENTS);
        end else begin
            ring_clamp = ring_ext;
        end
        ring_n   = NW'(ring_clamp);
        last_idx = AW'(ring_n - NW'(1));
    end

    assign in_idx = AW'(i_in.agent);
    assign a_l    = f_prev(r_a, last_idx);
    assign a_r    = f_next(r_a, last_idx);
    assign a_ll   = f_prev(a_l, last_idx);
    assign a_rr   = f_next(a_r, last_idx);

    assign rd_addr   = f_pick(i_cmd.rd_sel, in_idx, r_a, a_l, a_r, a_ll, a_rr);
    assign wr_addr   = f_pick(i_cmd.wr_sel, in_idx, r_a, a_l, a_r, a_ll, a_rr);
    assign emit_addr = f_pick(i_cmd.emit_sel, in_idx, r_a, a_l, a_r, a_ll, a_rr);

    assign rd_phase   = r_rd_vld ? r_rd_raw.phase : PH_IDLE;
    assign rd_stamp   = r_rd_vld ? r_rd_raw.stamp : '0;
    assign self_stamp = i_cmd.stop_self_now ? r_now : r_self_stamp;
    assign waited     = r_now - rd_stamp;
    assign older      = (rd_phase == PH_WAIT) && (rd_stamp < self_stamp)
                        && (waited >= STAMP_W'(r_wait_limit));
    assign stop       = (rd_phase == PH_GRANT) || older;

    assign wr_entry.phase = i_cmd.wr_grant ? PH_GRANT : PH_WAIT;
    assign wr_entry.stamp = i_cmd.wr_stamp_now ? r_now : r_self_stamp;

    assign o_sts.in_range  = XW'(i_in.agent) < XW'(ring_n);
    assign o_sts.rd_idle   = (rd_phase == PH_IDLE);
    assign o_sts.rd_wait   = (rd_phase == PH_WAIT);
    assign o_sts.stop      = stop;
    assign o_sts.stop_held = r_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size  <= RING_SIZE_RST;
            r_wait_limit <= WAIT_LIMIT_RST;
            r_now        <= '0;
            r_valid      <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_RING_SIZE:  r_ring_size  <= i_cfg_data[RING_SIZE_W-1:0];
                    CFG_WAIT_LIMIT: r_wait_limit <= i_cfg_data[WAIT_LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.tick && (r_now != '1)) begin
                r_now <= r_now + STAMP_W'(1);
            end
            if (i_cmd.clr_valid) begin
                r_valid[in_idx] <= 1'b0;
            end
            if (i_cmd.wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            r_res_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_raw <= r_mem[rd_addr];
            r_rd_vld <= r_valid[rd_addr];
        end
        if (i_cmd.load) begin
            r_a <= in_idx;
        end
        if (i_cmd.self_load) begin
            r_self_stamp <= rd_stamp;
        end
        if (i_cmd.stop_load) begin
            r_stop <= stop;
        end
        if (i_cmd.emit) begin
            r_res.granted_agent <= AGENT_W'(emit_addr);
            r_res.last          <= i_cmd.emit_last;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

### hdl/ring_neighbor_grant_arbiter_unit.sv
`timescale 1ns / 1ps
// Neighbor grant arbiter for a ring of agents. Pulse start with an item while busy
// is low: a tick leaves busy low, while a request or a release keeps busy high as
// the block steps through its table reads, a release longer when it grants both
// neighbors, because the agent table has a single read port and each test reads one
// entry per cycle. Each grant appears on o_res for exactly one cycle with o_res_valid
// high, registered from the final states of the item; the receiver cannot stall it.
// The configuration port is always ready and should only be written while idle.
module ring_neighbor_grant_arbiter_unit
    import rnga_pkg::*;
#(
    parameter int MAX_AGENTS = MAX_AGENTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in                   i_in,
    output logic                  o_res_valid,
    output t_out                  o_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    rnga_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_in.func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    rnga_datapath #(
        .MAX_AGENTS (MAX_AGENTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    assign o_cfg_ready = 1'b1;

endmodule

### tb/sv/ring_neighbor_grant_arbiter_unit_tb.sv
`timescale 1ns / 1ps
module ring_neighbor_grant_arbiter_unit_tb;
    import rnga_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_EVERY   = 40;
    localparam int SEG_ITEMS     = 64;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_in                   i_in        = '0;
    logic                  o_res_valid;
    t_out                  o_res;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    ring_neighbor_grant_arbiter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Mirror of the arbiter state.
    logic [PHASE_W-1:0]      phase_tab [MAX_AGENTS_DEF];
    logic [STAMP_W-1:0]      stamp_tab [MAX_AGENTS_DEF];
    logic [STAMP_W-1:0]      tick_now;
    logic [RING_SIZE_W-1:0]  ring_cfg;
    logic [WAIT_LIMIT_W-1:0] limit_cfg;

    t_in  items_to_send [$];
    t_out grants_due [$];
    t_out want;

    int  send_gap_pct  = 0;
    bit  drain_hold    = 1'b0;
    bit  accepted;
    int  items_taken   = 0;
    int  grants_seen   = 0;
    int  settings_used = 0;
    int  fail_count    = 0;
    int  stall_cycles  = 0;

    int seg_ring  [6] = '{8, 5, 0, 15, 6, 4};
    int seg_limit [6] = '{0, 3, 65535, 7, 2, 10};
    int seg_gap   [6] = '{31, 31, 53, 53, 0, 0};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int ring_len();
        if (ring_cfg < 3) return 3;
        if (ring_cfg > MAX_AGENTS_DEF) return MAX_AGENTS_DEF;
        return int'(ring_cfg);
    endfunction

    function automatic bit older_waiter(int nb, int self);
        logic [STAMP_W-1:0] age;
        age = tick_now - stamp_tab[nb];
        if (phase_tab[nb] != PH_WAIT) return 1'b0;
        if (!(stamp_tab[nb] < stamp_tab[self])) return 1'b0;
        return age >= STAMP_W'(limit_cfg);
    endfunction

    function automatic bit grant_ok(int a, int n);
        int l;
        int r;
        l = (a + n - 1) % n;
        r = (a + 1) % n;
        if (phase_tab[l] == PH_GRANT || phase_tab[r] == PH_GRANT) return 1'b0;
        if (older_waiter(l, a) || older_waiter(r, a)) return 1'b0;
        return 1'b1;
    endfunction

    task automatic apply_arbiter_event(t_in item);
        int n;
        int a;
        int l;
        int r;
        logic [AGENT_W-1:0] won [$];
        n = ring_len();
        a = int'(item.agent);
        l = (a + n - 1) % n;
        r = (a + 1) % n;
        case (item.func)
            FUNC_TICK: begin
                if (tick_now != '1) tick_now = tick_now + 1;
            end
            FUNC_REQ: begin
                if (a < n && phase_tab[a] == PH_IDLE) begin
                    phase_tab[a] = PH_WAIT;
                    stamp_tab[a] = tick_now;
                    if (grant_ok(a, n)) begin
                        phase_tab[a] = PH_GRANT;
                        won.push_back(AGENT_W'(a));
                    end
                end
            end
            FUNC_REL: begin
                if (a < n) begin
                    phase_tab[a] = PH_IDLE;
                    if (phase_tab[l] == PH_WAIT && grant_ok(l, n)) begin
                        phase_tab[l] = PH_GRANT;
                        won.push_back(AGENT_W'(l));
                    end
                    if (phase_tab[r] == PH_WAIT && grant_ok(r, n)) begin
                        phase_tab[r] = PH_GRANT;
                        won.push_back(AGENT_W'(r));
                    end
                end
            end
            default: begin
            end
        endcase
        foreach (won[k]) begin
            grants_due.push_back('{granted_agent: won[k], last: (k == won.size() - 1)});
        end
    endtask

    task automatic report_mismatch(string what, int got, int exp_val);
        $display("%0t mismatch: %s, got %0d, expected %0d", $time, what, got, exp_val);
        fail_count++;
    endtask

    // Driver: launches queued items, holds start while busy, pauses for a full drain now and then.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            accepted = start && !busy;
            if (accepted) begin
                apply_arbiter_event(i_in);
                items_taken++;
                if (items_taken % DRAIN_EVERY == 0) drain_hold = 1'b1;
            end
            if (start && !accepted) begin
            end else if (drain_hold) begin
                start <= 1'b0;
                if (!accepted && !busy && grants_due.size() == 0) drain_hold = 1'b0;
            end else if (items_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                start <= 1'b1;
                i_in  <= items_to_send.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every grant beat is compared with the oldest outstanding grant.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            grants_seen++;
            if (grants_due.size() == 0) begin
                report_mismatch("grant with none outstanding, agent", o_res.granted_agent, -1);
            end else begin
                want = grants_due.pop_front();
                if (o_res.granted_agent !== want.granted_agent)
                    report_mismatch("granted_agent", o_res.granted_agent, want.granted_agent);
                if (o_res.last !== want.last)
                    report_mismatch("last", o_res.last, want.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("%0t timeout with %0d grants outstanding", $time, grants_due.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic push_item(logic [FUNC_W-1:0] func, int agent);
        items_to_send.push_back('{func: func, agent: AGENT_W'(agent)});
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk);
        while (items_to_send.size() != 0 || start || busy || drain_hold || grants_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_RING_SIZE) ring_cfg = data[RING_SIZE_W-1:0];
        else if (idx == CFG_WAIT_LIMIT) limit_cfg = data;
        settings_used++;
    endtask

    // Mostly in-ring requests, releases and ticks; a few ignored items mixed in as noise.
    task automatic random_items(int count);
        int n;
        int roll;
        int taken;
        n = ring_len();
        taken = 0;
        @(negedge i_clk);
        while (taken < count) begin
            roll = $urandom_range(99);
            if (roll < 28) begin
                push_item(FUNC_TICK, $urandom_range(7));
                taken++;
            end else if (roll < 61) begin
                push_item(FUNC_REQ, $urandom_range(n - 1));
                taken++;
            end else if (roll < 94) begin
                push_item(FUNC_REL, $urandom_range(n - 1));
                taken++;
            end else if (roll < 97 || n == MAX_AGENTS_DEF) begin
                push_item(FUNC_UNUSED, $urandom_range(7));
            end else begin
                push_item(($urandom_range(1) == 0) ? FUNC_REQ : FUNC_REL,
                          $urandom_range(MAX_AGENTS_DEF - 1, n));
            end
        end
    endtask

    initial begin
        foreach (phase_tab[i]) begin
            phase_tab[i] = PH_IDLE;
            stamp_tab[i] = '0;
        end
        tick_now  = '0;
        ring_cfg  = RING_SIZE_RST;
        limit_cfg = WAIT_LIMIT_RST;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: grants, blocking by a granted neighbor, double grant on release,
        // repeated request, release of an idle agent, unused code and aging.
        send_gap_pct = 31;
        @(negedge i_clk);
        push_item(FUNC_TICK, 7);
        push_item(FUNC_REQ, 0);
        push_item(FUNC_REQ, 1);
        push_item(FUNC_REQ, 2);
        push_item(FUNC_REQ, 1);
        push_item(FUNC_REL, 0);
        push_item(FUNC_REL, 2);
        push_item(FUNC_REQ, 4);
        push_item(FUNC_REQ, 3);
        push_item(FUNC_REQ, 5);
        push_item(FUNC_REL, 4);
        push_item(FUNC_REQ, 7);
        push_item(FUNC_REL, 6);
        push_item(FUNC_UNUSED, 7);
        push_item(FUNC_REL, 7);
        push_item(FUNC_REQ, 6);
        repeat (10) push_item(FUNC_TICK, 0);
        push_item(FUNC_REQ, 7);
        push_item(FUNC_REL, 5);
        wait_quiet();

        // Smallest ring: agents beyond it are ignored, and a release sees the left grant.
        cfg_write(CFG_RING_SIZE, 16'd3);
        cfg_write(CFG_WAIT_LIMIT, 16'd0);
        @(negedge i_clk);
        push_item(FUNC_REL, 1);
        push_item(FUNC_REQ, 0);
        push_item(FUNC_REQ, 1);
        push_item(FUNC_REQ, 2);
        push_item(FUNC_REL, 0);
        push_item(FUNC_REQ, 5);
        push_item(FUNC_REL, 7);
        push_item(FUNC_UNUSED, 0);
        push_item(FUNC_REL, 2);
        wait_quiet();

        for (int s = 0; s < 6; s++) begin
            cfg_write(CFG_RING_SIZE, CFG_DATA_W'(seg_ring[s]));
            cfg_write(CFG_WAIT_LIMIT, CFG_DATA_W'(seg_limit[s]));
            send_gap_pct = seg_gap[s];
            random_items(SEG_ITEMS);
            wait_quiet();
        end
        repeat (20) @(posedge i_clk);

        $display("Ran %0d items, %0d register writes, ring sizes 3 to 8, limits 0 to 65535.",
                 items_taken, settings_used);
        $display("Checked %0d grant beats, %0d mismatches.", grants_seen, fail_count);
        if (fail_count == 0 && grants_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/rnga_pkg.sv
hdl/rnga_ctrl.sv
hdl/rnga_datapath.sv
hdl/ring_neighbor_grant_arbiter_unit.sv
tb/sv/ring_neighbor_grant_arbiter_unit_tb.sv
